### rtl/core/mde_pkg.sv
// ---------------------------------------------------------------------------
// mde_pkg
// Shared types and constants of the depth-first maze explorer: transaction
// payloads, cell map word, register indexes, status and heading codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mde_pkg;

    // default grid and stack sizes
    localparam int GRID_WIDTH_DEF  = 16;
    localparam int GRID_HEIGHT_DEF = 16;
    localparam int STACK_DEPTH_DEF = 256;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_GOAL_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GOAL_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOME_X = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOME_Y = 2'd3;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] GOAL_X_RST = 4'd7;
    localparam logic [CFG_DATA_W-1:0] GOAL_Y_RST = 4'd7;
    localparam logic [CFG_DATA_W-1:0] HOME_X_RST = 4'd0;
    localparam logic [CFG_DATA_W-1:0] HOME_Y_RST = 4'd0;

    // run status codes
    localparam logic [1:0] STATUS_EXPLORE = 2'd0;
    localparam logic [1:0] STATUS_GOAL    = 2'd1;
    localparam logic [1:0] STATUS_NO_PATH = 2'd2;

    // heading codes, also wall map bit positions
    localparam logic [1:0] HEAD_NORTH = 2'd0;
    localparam logic [1:0] HEAD_EAST  = 2'd1;
    localparam logic [1:0] HEAD_SOUTH = 2'd2;
    localparam logic [1:0] HEAD_WEST  = 2'd3;

    // sensor transaction
    typedef struct packed {
        logic wall_ahead;
        logic wall_on_right;
        logic wall_on_left;
    } sense_t;

    // move transaction
    typedef struct packed {
        logic [1:0] turn_count;
        logic       turn_clockwise;
        logic       step_forward;
        logic [1:0] new_heading;
        logic [3:0] next_x;
        logic [3:0] next_y;
        logic [1:0] status;
    } move_t;

    // one cell map word
    typedef struct packed {
        logic       visited;
        logic [3:0] walls;
    } cell_t;

endpackage

`default_nettype wire

### rtl/core/mde_ram.sv
// ---------------------------------------------------------------------------
// mde_ram
// Generic single-write, single-read memory with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/maze_depth_first_explorer_top.sv
// ---------------------------------------------------------------------------
// maze_depth_first_explorer_top
// Depth-first micromouse maze explorer. Each sensor transaction is the
// arrival at the current cell; the block records walls, picks the next
// cell (first open unvisited neighbor N/E/S/W, else backtrack along the
// path stack) and returns one move transaction.
//
// Usage:
//  - sense channel (sense_valid/sense_stall/sense) carries the three wall
//    sensor bits; one input buffer lets the next transaction in while the
//    current one is worked on.
//  - move channel (move_valid/move_stall/move) carries turn, step, heading,
//    new cell and status; an output register holds a result while the
//    receiver stalls, and the sequencer waits only when a second result is ready.
//  - a normal step runs the sequencer through S_IDLE, S_RD_N, S_RD_E, S_RD_S,
//    S_RD_W, S_DECIDE and S_EMIT, one cell map read each for the cell and
//    its four neighbors; goal and finished pass only S_IDLE and S_EMIT.
//  - after reset all GRID_WIDTH*GRID_HEIGHT cells (256 by default) of the
//    cell map are swept clear with sense_stall high; cfg_* writes while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module maze_depth_first_explorer_top #(
    parameter int GRID_WIDTH  = mde_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = mde_pkg::GRID_HEIGHT_DEF,
    parameter int STACK_DEPTH = mde_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               sense_valid,
    output logic                                    sense_stall,
    input  wire mde_pkg::sense_t                    sense,

    output logic                                    move_valid,
    input  wire logic                               move_stall,
    output mde_pkg::move_t                          move,

    input  wire logic                               cfg_we,
    input  wire logic [mde_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mde_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // derived sizes
    localparam int XB    = $clog2(GRID_WIDTH);
    localparam int YB    = $clog2(GRID_HEIGHT);
    localparam int GB    = (XB > YB) ? XB : YB;
    localparam int CW    = (GB > mde_pkg::CFG_DATA_W) ? GB : mde_pkg::CFG_DATA_W;
    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int SCW   = $clog2(STACK_DEPTH + 1);
    localparam int LW    = AW + CW + 1;
    localparam int EW    = 2 * CW;

    // sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RD_N   = 3'd2;
    localparam logic [2:0] S_RD_E   = 3'd3;
    localparam logic [2:0] S_RD_S   = 3'd4;
    localparam logic [2:0] S_RD_W   = 3'd5;
    localparam logic [2:0] S_DECIDE = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    // control registers
    logic [2:0]                     state_reg, state_next;
    logic [AW-1:0]                  clear_cnt_reg, clear_cnt_next;
    logic [mde_pkg::CFG_DATA_W-1:0] goal_x_reg, goal_x_next;
    logic [mde_pkg::CFG_DATA_W-1:0] goal_y_reg, goal_y_next;
    logic [mde_pkg::CFG_DATA_W-1:0] home_x_reg, home_x_next;
    logic [mde_pkg::CFG_DATA_W-1:0] home_y_reg, home_y_next;
    logic [CW-1:0]                  cur_x_reg, cur_x_next;
    logic [CW-1:0]                  cur_y_reg, cur_y_next;
    logic [1:0]                     heading_reg, heading_next;
    logic [SCW-1:0]                 stack_count_reg, stack_count_next;
    logic [1:0]                     finish_reg, finish_next;
    logic                           buf_valid_reg, buf_valid_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           pushed0_reg, pushed0_next;

    // payload registers
    mde_pkg::sense_t                buf_reg, buf_next;
    mde_pkg::sense_t                work_sense_reg, work_sense_next;
    logic [EW-1:0]                  top_reg, top_next;
    logic [EW-1:0]                  second_reg, second_next;
    logic                           top_hit_reg, top_hit_next;
    logic [3:0]                     walls_reg, walls_next;
    logic [2:0]                     vis_reg, vis_next;
    mde_pkg::move_t                 res_reg, res_next;
    mde_pkg::move_t                 out_reg, out_next;

    // memory ports
    logic                           map_we;
    logic [AW-1:0]                  map_waddr;
    mde_pkg::cell_t                 map_wdata;
    logic [AW-1:0]                  map_raddr;
    mde_pkg::cell_t                 map_rdata;
    logic                           stk_we;
    logic [SAW-1:0]                 stk_waddr;
    logic [EW-1:0]                  stk_wdata;
    logic [SAW-1:0]                 stk_raddr;
    logic [EW-1:0]                  stk_rdata;

    // neighbor geometry
    logic [CW:0]                    nb_x [4];
    logic [CW:0]                    nb_y [4];
    logic [3:0]                     nb_in;
    logic                           cur_inside;
    logic                           at_home;
    logic                           at_goal;
    logic [LW-1:0]                  cur_lin;
    logic [LW-1:0]                  rd_lin;
    logic [CW:0]                    rd_x;
    logic [CW:0]                    rd_y;
    logic [SCW-1:0]                 cnt_m1;
    logic [SCW-1:0]                 cnt_m2;
    logic                           stack_room;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    mde_ram #(
        .WIDTH ($bits(mde_pkg::cell_t)),
        .DEPTH (CELLS)
    ) u_cell_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    mde_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_path_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // ------------------------------------------------------------------
    // neighbor cells of the current cell, with in-grid flags
    // ------------------------------------------------------------------
    always_comb
    begin
        nb_x[mde_pkg::HEAD_NORTH] = {1'b0, cur_x_reg};
        nb_y[mde_pkg::HEAD_NORTH] = {1'b0, cur_y_reg} + (CW+1)'(1);
        nb_x[mde_pkg::HEAD_EAST]  = {1'b0, cur_x_reg} + (CW+1)'(1);
        nb_y[mde_pkg::HEAD_EAST]  = {1'b0, cur_y_reg};
        nb_x[mde_pkg::HEAD_SOUTH] = {1'b0, cur_x_reg};
        nb_y[mde_pkg::HEAD_SOUTH] = {1'b0, cur_y_reg} - (CW+1)'(1);
        nb_x[mde_pkg::HEAD_WEST]  = {1'b0, cur_x_reg} - (CW+1)'(1);
        nb_y[mde_pkg::HEAD_WEST]  = {1'b0, cur_y_reg};

        nb_in[mde_pkg::HEAD_NORTH] = (nb_x[mde_pkg::HEAD_NORTH] < (CW+1)'(GRID_WIDTH))
                                  && (nb_y[mde_pkg::HEAD_NORTH] < (CW+1)'(GRID_HEIGHT));
        nb_in[mde_pkg::HEAD_EAST]  = (nb_x[mde_pkg::HEAD_EAST] < (CW+1)'(GRID_WIDTH))
                                  && (nb_y[mde_pkg::HEAD_EAST] < (CW+1)'(GRID_HEIGHT));
        nb_in[mde_pkg::HEAD_SOUTH] = (cur_y_reg != '0)
                                  && (nb_x[mde_pkg::HEAD_SOUTH] < (CW+1)'(GRID_WIDTH))
                                  && (nb_y[mde_pkg::HEAD_SOUTH] < (CW+1)'(GRID_HEIGHT));
        nb_in[mde_pkg::HEAD_WEST]  = (cur_x_reg != '0)
                                  && (nb_x[mde_pkg::HEAD_WEST] < (CW+1)'(GRID_WIDTH))
                                  && (nb_y[mde_pkg::HEAD_WEST] < (CW+1)'(GRID_HEIGHT));
    end

    // current cell flags and linear addresses
    assign cur_inside = ({1'b0, cur_x_reg} < (CW+1)'(GRID_WIDTH))
                     && ({1'b0, cur_y_reg} < (CW+1)'(GRID_HEIGHT));
    assign at_home    = (cur_x_reg == CW'(home_x_reg)) && (cur_y_reg == CW'(home_y_reg));
    assign at_goal    = (cur_x_reg == CW'(goal_x_reg)) && (cur_y_reg == CW'(goal_y_reg));
    assign cur_lin    = LW'(cur_y_reg) * LW'(GRID_WIDTH) + LW'(cur_x_reg);
    assign rd_lin     = LW'(rd_y) * LW'(GRID_WIDTH) + LW'(rd_x);
    assign map_raddr  = rd_lin[AW-1:0];

    // stack pointers
    assign cnt_m1     = stack_count_reg - SCW'(1);
    assign cnt_m2     = stack_count_reg - SCW'(2);
    assign stack_room = stack_count_reg < SCW'(STACK_DEPTH);

    // handshakes
    assign sense_stall = buf_valid_reg || (state_reg == S_CLEAR);
    assign move_valid  = out_valid_reg;
    assign move        = out_reg;

    // ------------------------------------------------------------------
    // sequencer and next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [3:0] new_walls;
        logic [1:0] rel_dir;
        logic [3:0] free_dir;
        logic [3:0] adj_dir;
        logic [3:0] vis_all;
        logic [1:0] target;
        logic       have_target;
        logic [SCW-1:0] count_bt;
        logic [EW-1:0]  bt_entry;
        logic [CW:0]    bt_x;
        logic [CW:0]    bt_y;
        mde_pkg::cell_t cur_word;

        state_next       = state_reg;
        clear_cnt_next   = clear_cnt_reg;
        goal_x_next      = goal_x_reg;
        goal_y_next      = goal_y_reg;
        home_x_next      = home_x_reg;
        home_y_next      = home_y_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        heading_next     = heading_reg;
        stack_count_next = stack_count_reg;
        finish_next      = finish_reg;
        buf_valid_next   = buf_valid_reg;
        out_valid_next   = out_valid_reg;
        pushed0_next     = pushed0_reg;
        buf_next         = buf_reg;
        work_sense_next  = work_sense_reg;
        top_next         = top_reg;
        second_next      = second_reg;
        top_hit_next     = top_hit_reg;
        walls_next       = walls_reg;
        vis_next         = vis_reg;
        res_next         = res_reg;
        out_next         = out_reg;

        map_we    = 1'b0;
        map_waddr = cur_lin[AW-1:0];
        map_wdata = '0;
        stk_we    = 1'b0;
        stk_waddr = stack_count_reg[SAW-1:0];
        stk_wdata = {cur_x_reg, cur_y_reg};
        stk_raddr = cnt_m1[SAW-1:0];
        rd_x      = {1'b0, cur_x_reg};
        rd_y      = {1'b0, cur_y_reg};

        new_walls   = '0;
        rel_dir     = '0;
        cur_word    = map_rdata;
        vis_all     = {map_rdata.visited, vis_reg};
        free_dir    = '0;
        adj_dir     = '0;
        target      = heading_reg;
        have_target = 1'b0;
        count_bt    = top_hit_reg ? cnt_m1 : stack_count_reg;
        bt_entry    = top_hit_reg ? second_reg : top_reg;
        bt_x        = {1'b0, bt_entry[EW-1:CW]};
        bt_y        = {1'b0, bt_entry[CW-1:0]};

        // input buffer fill
        if (sense_valid && !sense_stall)
        begin
            buf_valid_next = 1'b1;
            buf_next       = sense;
        end

        // output register drain
        if (out_valid_reg && !move_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            // sweep the cell map to all clear
            S_CLEAR:
            begin
                map_we         = 1'b1;
                map_waddr      = clear_cnt_reg;
                map_wdata      = '0;
                clear_cnt_next = clear_cnt_reg + AW'(1);
                if (clear_cnt_reg == AW'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // start a transaction: read current cell and stack top
            S_IDLE:
            begin
                if (buf_valid_reg)
                begin
                    buf_valid_next  = 1'b0;
                    work_sense_next = buf_reg;
                    res_next        = '{turn_count: 2'd0, turn_clockwise: 1'b0,
                                        step_forward: 1'b0, new_heading: heading_reg,
                                        next_x: cur_x_reg[3:0], next_y: cur_y_reg[3:0],
                                        status: finish_reg};
                    if (finish_reg != mde_pkg::STATUS_EXPLORE)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (at_goal)
                    begin
                        stk_we          = stack_room;
                        stack_count_next = stack_room ? stack_count_reg + SCW'(1)
                                                      : stack_count_reg;
                        finish_next     = mde_pkg::STATUS_GOAL;
                        res_next.status = mde_pkg::STATUS_GOAL;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        // empty stack: current cell goes in first
                        pushed0_next = (stack_count_reg == '0);
                        if (stack_count_reg == '0)
                        begin
                            stk_we           = 1'b1;
                            stack_count_next = SCW'(1);
                        end
                        state_next = S_RD_N;
                    end
                end
            end

            // record walls on first visit, read north neighbor
            S_RD_N:
            begin
                for (int j = 0; j < 4; j++)
                begin
                    rel_dir = 2'(j) - heading_reg;
                    unique case (rel_dir)
                        2'd0:    new_walls[j] = work_sense_reg.wall_ahead;
                        2'd1:    new_walls[j] = work_sense_reg.wall_on_right;
                        2'd3:    new_walls[j] = work_sense_reg.wall_on_left;
                        default: new_walls[j] = at_home ? cur_word.walls[j] : 1'b0;
                    endcase
                end
                if (!cur_inside)
                begin
                    walls_next = 4'hF;
                end
                else if (!cur_word.visited)
                begin
                    map_we     = 1'b1;
                    map_wdata  = '{visited: 1'b1, walls: new_walls};
                    walls_next = new_walls;
                end
                else
                begin
                    walls_next = cur_word.walls;
                end
                top_next     = stk_rdata;
                top_hit_next = pushed0_reg || (stk_rdata == {cur_x_reg, cur_y_reg});
                stk_raddr    = cnt_m2[SAW-1:0];
                rd_x         = nb_x[mde_pkg::HEAD_NORTH];
                rd_y         = nb_y[mde_pkg::HEAD_NORTH];
                state_next   = S_RD_E;
            end

            S_RD_E:
            begin
                second_next = stk_rdata;
                vis_next[0] = map_rdata.visited;
                rd_x        = nb_x[mde_pkg::HEAD_EAST];
                rd_y        = nb_y[mde_pkg::HEAD_EAST];
                state_next  = S_RD_S;
            end

            S_RD_S:
            begin
                vis_next[1] = map_rdata.visited;
                rd_x        = nb_x[mde_pkg::HEAD_SOUTH];
                rd_y        = nb_y[mde_pkg::HEAD_SOUTH];
                state_next  = S_RD_W;
            end

            S_RD_W:
            begin
                vis_next[2] = map_rdata.visited;
                rd_x        = nb_x[mde_pkg::HEAD_WEST];
                rd_y        = nb_y[mde_pkg::HEAD_WEST];
                state_next  = S_DECIDE;
            end

            // pick forward move or backtrack
            S_DECIDE:
            begin
                for (int d = 0; d < 4; d++)
                begin
                    free_dir[d] = !walls_reg[d] && nb_in[d] && !vis_all[d];
                    adj_dir[d]  = nb_in[d] && (nb_x[d] == bt_x) && (nb_y[d] == bt_y);
                end
                state_next = S_EMIT;
                res_next   = '{turn_count: 2'd0, turn_clockwise: 1'b0,
                               step_forward: 1'b0, new_heading: heading_reg,
                               next_x: cur_x_reg[3:0], next_y: cur_y_reg[3:0],
                               status: mde_pkg::STATUS_NO_PATH};

                if (free_dir != '0)
                begin
                    have_target = 1'b1;
                    priority if (free_dir[0]) target = mde_pkg::HEAD_NORTH;
                    else if (free_dir[1])     target = mde_pkg::HEAD_EAST;
                    else if (free_dir[2])     target = mde_pkg::HEAD_SOUTH;
                    else                      target = mde_pkg::HEAD_WEST;
                    if (!top_hit_reg && stack_room)
                    begin
                        stk_we           = 1'b1;
                        stack_count_next = stack_count_reg + SCW'(1);
                    end
                end
                else
                begin
                    stack_count_next = count_bt;
                    if ((count_bt != '0) && (adj_dir != '0))
                    begin
                        have_target = 1'b1;
                        priority if (adj_dir[0]) target = mde_pkg::HEAD_NORTH;
                        else if (adj_dir[1])     target = mde_pkg::HEAD_EAST;
                        else if (adj_dir[2])     target = mde_pkg::HEAD_SOUTH;
                        else                     target = mde_pkg::HEAD_WEST;
                    end
                    else
                    begin
                        finish_next = mde_pkg::STATUS_NO_PATH;
                    end
                end

                if (have_target)
                begin
                    heading_next            = target;
                    cur_x_next              = nb_x[target][CW-1:0];
                    cur_y_next              = nb_y[target][CW-1:0];
                    res_next.step_forward   = 1'b1;
                    res_next.new_heading    = target;
                    res_next.next_x         = nb_x[target][3:0];
                    res_next.next_y         = nb_y[target][3:0];
                    res_next.status         = mde_pkg::STATUS_EXPLORE;
                    if (target > heading_reg)
                    begin
                        res_next.turn_count     = target - heading_reg;
                        res_next.turn_clockwise = 1'b1;
                    end
                    else
                    begin
                        res_next.turn_count     = heading_reg - target;
                        res_next.turn_clockwise = 1'b0;
                    end
                end
            end

            // hand result to the output register
            S_EMIT:
            begin
                if (!out_valid_reg || !move_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                mde_pkg::REG_GOAL_X: goal_x_next = cfg_data;
                mde_pkg::REG_GOAL_Y: goal_y_next = cfg_data;
                mde_pkg::REG_HOME_X:
                begin
                    home_x_next = cfg_data;
                    if (stack_count_reg == '0 && finish_reg == mde_pkg::STATUS_EXPLORE)
                    begin
                        cur_x_next = CW'(cfg_data);
                    end
                end
                mde_pkg::REG_HOME_Y:
                begin
                    home_y_next = cfg_data;
                    if (stack_count_reg == '0 && finish_reg == mde_pkg::STATUS_EXPLORE)
                    begin
                        cur_y_next = CW'(cfg_data);
                    end
                end
                default:
                begin
                    goal_x_next = goal_x_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clear_cnt_reg   <= '0;
            goal_x_reg      <= mde_pkg::GOAL_X_RST;
            goal_y_reg      <= mde_pkg::GOAL_Y_RST;
            home_x_reg      <= mde_pkg::HOME_X_RST;
            home_y_reg      <= mde_pkg::HOME_Y_RST;
            cur_x_reg       <= CW'(mde_pkg::HOME_X_RST);
            cur_y_reg       <= CW'(mde_pkg::HOME_Y_RST);
            heading_reg     <= mde_pkg::HEAD_NORTH;
            stack_count_reg <= '0;
            finish_reg      <= mde_pkg::STATUS_EXPLORE;
            buf_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            pushed0_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clear_cnt_reg   <= clear_cnt_next;
            goal_x_reg      <= goal_x_next;
            goal_y_reg      <= goal_y_next;
            home_x_reg      <= home_x_next;
            home_y_reg      <= home_y_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            heading_reg     <= heading_next;
            stack_count_reg <= stack_count_next;
            finish_reg      <= finish_next;
            buf_valid_reg   <= buf_valid_next;
            out_valid_reg   <= out_valid_next;
            pushed0_reg     <= pushed0_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        buf_reg        <= buf_next;
        work_sense_reg <= work_sense_next;
        top_reg        <= top_next;
        second_reg     <= second_next;
        top_hit_reg    <= top_hit_next;
        walls_reg      <= walls_next;
        vis_reg        <= vis_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

endmodule

`default_nettype wire

### test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the depth-first maze explorer. A hidden random
// maze feeds sensor transactions from the predicted mouse position, with
// noise and fixed patterns mixed in. A scoreboard replays the exploration
// (wall map, visited map, path stack, turns) and checks every move
// transaction field by field, while both channels idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import mde_pkg::*;

    localparam int GW        = GRID_WIDTH_DEF;
    localparam int GH        = GRID_HEIGHT_DEF;
    localparam int MAX_CYCLE = 400000;

    // predicts the explorer's moves and checks the move transactions
    class move_scoreboard;
        logic [3:0] goal_x, goal_y, home_x, home_y;
        logic [3:0] cur_x, cur_y;
        logic [1:0] heading;
        logic [1:0] run_status;
        bit         visited [0:GW*GH-1];
        logic [3:0] wall_map [0:GW*GH-1];
        logic [3:0] trail_x [0:STACK_DEPTH_DEF-1];
        logic [3:0] trail_y [0:STACK_DEPTH_DEF-1];
        int         trail_depth;
        move_t      pending_moves [$];
        int         mismatches;

        function new();
            goal_x      = GOAL_X_RST;
            goal_y      = GOAL_Y_RST;
            home_x      = HOME_X_RST;
            home_y      = HOME_Y_RST;
            cur_x       = HOME_X_RST;
            cur_y       = HOME_Y_RST;
            heading     = HEAD_NORTH;
            run_status  = STATUS_EXPLORE;
            trail_depth = 0;
            mismatches  = 0;
            foreach (visited[i])
            begin
                visited[i]  = 1'b0;
                wall_map[i] = 4'b0000;
            end
        endfunction

        // neighbor on side d, 0 when it falls outside the grid
        function bit step_to(input logic [3:0] x, input logic [3:0] y,
                             input logic [1:0] d,
                             output logic [3:0] nx, output logic [3:0] ny);
            int ix, iy;
            ix = x;
            iy = y;
            case (d)
                HEAD_NORTH: iy = iy + 1;
                HEAD_EAST:  ix = ix + 1;
                HEAD_SOUTH: iy = iy - 1;
                default:    ix = ix - 1;
            endcase
            nx = ix[3:0];
            ny = iy[3:0];
            return ix >= 0 && ix < GW && iy >= 0 && iy < GH;
        endfunction

        function void push_cell(input logic [3:0] x, input logic [3:0] y);
            if (trail_depth < STACK_DEPTH_DEF)
            begin
                trail_x[trail_depth] = x;
                trail_y[trail_depth] = y;
                trail_depth++;
            end
        endfunction

        function bit on_top(input logic [3:0] x, input logic [3:0] y);
            return trail_depth > 0 && trail_x[trail_depth-1] == x
                   && trail_y[trail_depth-1] == y;
        endfunction

        // register write; home also moves the mouse before the run starts
        function void write_reg(input logic [1:0] idx, input logic [3:0] val);
            bit idle;
            idle = (trail_depth == 0 && run_status == STATUS_EXPLORE);
            case (idx)
                REG_GOAL_X: goal_x = val;
                REG_GOAL_Y: goal_y = val;
                REG_HOME_X:
                begin
                    home_x = val;
                    if (idle) cur_x = val;
                end
                default:
                begin
                    home_y = val;
                    if (idle) cur_y = val;
                end
            endcase
        endfunction

        // one arrival at the current cell
        function move_t predict_move(input sense_t s);
            move_t      m;
            logic [7:0] spot;
            logic [3:0] w, walls, nx, ny, ax, ay;
            logic [3:0] sensed;
            logic [1:0] side, dir;
            bit         have_dir;
            int         d;
            m             = '0;
            m.new_heading = heading;
            m.next_x      = cur_x;
            m.next_y      = cur_y;
            m.status      = run_status;
            if (run_status != STATUS_EXPLORE) return m;

            // goal cell ends the run
            if (cur_x == goal_x && cur_y == goal_y)
            begin
                push_cell(cur_x, cur_y);
                run_status = STATUS_GOAL;
                m.status   = STATUS_GOAL;
                return m;
            end
            if (trail_depth == 0) push_cell(cur_x, cur_y);

            // first visit records walls, rotated by heading
            spot = {cur_y, cur_x};
            if (!visited[spot])
            begin
                w      = wall_map[spot];
                sensed = {s.wall_on_left, 1'b0, s.wall_on_right, s.wall_ahead};
                for (d = 0; d < 4; d++)
                begin
                    side = heading + d[1:0];
                    if (d == 2)
                    begin
                        if (!(cur_x == home_x && cur_y == home_y)) w[side] = 1'b0;
                    end
                    else
                    begin
                        w[side] = sensed[d];
                    end
                end
                wall_map[spot] = w;
                visited[spot]  = 1'b1;
            end
            walls = wall_map[spot];

            // first open unvisited neighbor, north first
            have_dir = 1'b0;
            dir      = HEAD_NORTH;
            for (d = 0; d < 4; d++)
            begin
                if (!have_dir && !walls[d] && step_to(cur_x, cur_y, d[1:0], nx, ny)
                    && !visited[{ny, nx}])
                begin
                    dir      = d[1:0];
                    have_dir = 1'b1;
                end
            end

            if (have_dir)
            begin
                if (!on_top(cur_x, cur_y)) push_cell(cur_x, cur_y);
                void'(step_to(cur_x, cur_y, dir, nx, ny));
            end
            else
            begin
                // backtrack along the path stack
                if (on_top(cur_x, cur_y)) trail_depth--;
                if (trail_depth == 0)
                begin
                    run_status = STATUS_NO_PATH;
                    m.status   = STATUS_NO_PATH;
                    return m;
                end
                nx = trail_x[trail_depth-1];
                ny = trail_y[trail_depth-1];
                for (d = 0; d < 4; d++)
                begin
                    if (!have_dir && step_to(cur_x, cur_y, d[1:0], ax, ay)
                        && ax == nx && ay == ny)
                    begin
                        dir      = d[1:0];
                        have_dir = 1'b1;
                    end
                end
                if (!have_dir)
                begin
                    run_status = STATUS_NO_PATH;
                    m.status   = STATUS_NO_PATH;
                    return m;
                end
            end

            // turn toward the chosen side
            if (dir > heading)
            begin
                m.turn_count     = dir - heading;
                m.turn_clockwise = 1'b1;
            end
            else
            begin
                m.turn_count     = heading - dir;
                m.turn_clockwise = 1'b0;
            end
            m.step_forward = 1'b1;
            m.new_heading  = dir;
            m.next_x       = nx;
            m.next_y       = ny;
            m.status       = STATUS_EXPLORE;
            heading        = dir;
            cur_x          = nx;
            cur_y          = ny;
            return m;
        endfunction

        function void note_sense(input sense_t s);
            move_t m;
            m = predict_move(s);
            pending_moves.insert(pending_moves.size(), m);
        endfunction

        function void check_move(input move_t got);
            move_t want;
            if (pending_moves.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected move transaction %h", got);
                return;
            end
            want = pending_moves.pop_front();
            if (got.turn_count !== want.turn_count
                || got.turn_clockwise !== want.turn_clockwise
                || got.step_forward !== want.step_forward
                || got.new_heading !== want.new_heading
                || got.next_x !== want.next_x || got.next_y !== want.next_y
                || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display({"move mismatch expected: turns %0d cw %0b fwd %0b",
                              " head %0d at %0d,%0d st %0d"},
                             want.turn_count, want.turn_clockwise, want.step_forward,
                             want.new_heading, want.next_x, want.next_y, want.status);
                    $display({"               actual:   turns %0d cw %0b fwd %0b",
                              " head %0d at %0d,%0d st %0d"},
                             got.turn_count, got.turn_clockwise, got.step_forward,
                             got.new_heading, got.next_x, got.next_y, got.status);
                end
            end
        endfunction
    endclass

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       sense_valid = 1'b0;
    logic       sense_stall;
    sense_t     sense       = '0;
    logic       move_valid;
    logic       move_stall  = 1'b0;
    move_t      move;
    logic       cfg_we      = 1'b0;
    logic [1:0] cfg_index   = REG_GOAL_X;
    logic [3:0] cfg_data    = 4'd0;

    move_scoreboard sb;
    logic [3:0]     maze_walls [0:GW*GH-1];
    bit             calm = 1'b0;
    int unsigned    cycles = 0;

    maze_depth_first_explorer_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .sense_valid (sense_valid),
        .sense_stall (sense_stall),
        .sense       (sense),
        .move_valid  (move_valid),
        .move_stall  (move_stall),
        .move        (move),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver stalls
    always @(posedge clk)
        move_stall <= !calm && ($urandom_range(0, 99) < 22);

    // move monitor
    always @(posedge clk)
        if (rst_n && move_valid && !move_stall) sb.check_move(move);

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == MAX_CYCLE)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // random maze with shared walls, closed border, home open to every in-grid neighbor
    function automatic void build_maze();
        int         x, y, idx, d;
        logic [3:0] nx, ny;
        logic [1:0] dd;
        foreach (maze_walls[i]) maze_walls[i] = 4'b0000;
        for (y = 0; y < GH; y++)
        begin
            for (x = 0; x < GW; x++)
            begin
                idx = y * GW + x;
                if (y == GH - 1)
                    maze_walls[idx][HEAD_NORTH] = 1'b1;
                else if ($urandom_range(0, 99) < 35)
                begin
                    maze_walls[idx][HEAD_NORTH]      = 1'b1;
                    maze_walls[idx + GW][HEAD_SOUTH] = 1'b1;
                end
                if (x == GW - 1)
                    maze_walls[idx][HEAD_EAST] = 1'b1;
                else if ($urandom_range(0, 99) < 35)
                begin
                    maze_walls[idx][HEAD_EAST]     = 1'b1;
                    maze_walls[idx + 1][HEAD_WEST] = 1'b1;
                end
                if (y == 0) maze_walls[idx][HEAD_SOUTH] = 1'b1;
                if (x == 0) maze_walls[idx][HEAD_WEST] = 1'b1;
            end
        end
        for (d = 0; d < 4; d++)
        begin
            dd = d[1:0];
            if (sb.step_to(sb.home_x, sb.home_y, dd, nx, ny))
            begin
                maze_walls[{sb.home_y, sb.home_x}][dd] = 1'b0;
                maze_walls[{ny, nx}][dd + 2'd2]        = 1'b0;
            end
        end
    endfunction

    // sensor bits at the predicted position; the goal side always reads closed
    function automatic sense_t take_reading(input bit from_maze, input logic [2:0] pattern,
                                            input int noise_pct);
        sense_t     s;
        logic [2:0] bits;
        logic [1:0] side;
        logic [3:0] w, nx, ny;
        int         k;
        w = maze_walls[{sb.cur_y, sb.cur_x}];
        for (k = 0; k < 3; k++)
        begin
            side    = sb.heading + ((k == 0) ? HEAD_NORTH : (k == 1) ? HEAD_EAST : HEAD_WEST);
            bits[k] = from_maze ? w[side] : pattern[k];
            if ($urandom_range(0, 99) < noise_pct) bits[k] = ~bits[k];
            if (sb.step_to(sb.cur_x, sb.cur_y, side, nx, ny) && nx == sb.goal_x
                && ny == sb.goal_y)
                bits[k] = 1'b1;
        end
        s.wall_ahead    = bits[0];
        s.wall_on_right = bits[1];
        s.wall_on_left  = bits[2];
        return s;
    endfunction

    // one sensor transaction, noted on acceptance
    task automatic drive_item(input sense_t s);
        sense_valid <= 1'b1;
        sense       <= s;
        @(posedge clk);
        while (sense_stall) @(posedge clk);
        sb.note_sense(s);
    endtask

    // random sender gap
    task automatic pause_sense();
        if (!calm && $urandom_range(0, 99) < 22)
        begin
            sense_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [3:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // wait for every expected move, then let the block settle
    task automatic drain();
        sense_valid <= 1'b0;
        while (sb.pending_moves.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [2:0] patterns [0:7];
        logic [3:0] hx, hy, gx, gy;
        bit         goal_mode;
        int         phase, i, noise;
        patterns  = '{3'b000, 3'b001, 3'b010, 3'b100, 3'b011, 3'b101, 3'b110, 3'b111};
        sb        = new();
        goal_mode = $urandom_range(0, 1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (sense_stall) @(posedge clk);

        // extremes of every register, then the run's own start and goal
        program_reg(REG_GOAL_X, 4'd0);
        program_reg(REG_GOAL_Y, 4'd15);
        program_reg(REG_GOAL_X, 4'd15);
        program_reg(REG_GOAL_Y, 4'd0);
        program_reg(REG_HOME_X, 4'd15);
        program_reg(REG_HOME_Y, 4'd15);
        program_reg(REG_HOME_X, 4'd0);
        program_reg(REG_HOME_Y, 4'd0);
        hx = 4'($urandom_range(0, 15));
        hy = 4'($urandom_range(0, 15));
        do
        begin
            gx = 4'($urandom_range(0, 15));
            gy = 4'($urandom_range(0, 15));
        end
        while (gx == hx && gy == hy);
        program_reg(REG_HOME_X, hx);
        program_reg(REG_HOME_Y, hy);
        program_reg(REG_GOAL_X, gx);
        program_reg(REG_GOAL_Y, gy);
        cfg_we <= 1'b0;
        build_maze();

        // start cell, every sensor pattern, then clean maze readings
        drive_item(take_reading(1'b1, 3'b000, 0));
        pause_sense();
        for (i = 0; i < 8; i++)
        begin
            drive_item(take_reading(1'b0, patterns[i], 0));
            pause_sense();
        end
        for (i = 0; i < 11; i++)
        begin
            drive_item(take_reading(1'b1, 3'b000, 0));
            pause_sense();
        end
        drain();

        // random exploration phases
        for (phase = 0; phase < 8; phase++)
        begin
            calm  = (phase == 2);
            noise = (phase == 5) ? 25 : 8;
            for (i = 0; i < 100; i++)
            begin
                drive_item(take_reading(1'b1, 3'b000, noise));
                pause_sense();
            end
            drain();
            calm = 1'b0;

            // move the goal under the mouse, or shift the home cell
            if (goal_mode && phase == 3 && sb.run_status == STATUS_EXPLORE)
            begin
                program_reg(REG_GOAL_X, sb.cur_x);
                program_reg(REG_GOAL_Y, sb.cur_y);
            end
            else
            begin
                program_reg(REG_HOME_X, ($urandom_range(0, 4) == 0) ? 4'd15
                                                                     : 4'($urandom_range(0, 15)));
                program_reg(REG_HOME_Y, ($urandom_range(0, 4) == 0) ? 4'd0
                                                                     : 4'($urandom_range(0, 15)));
            end
            cfg_we <= 1'b0;
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### maze_depth_first_explorer_top.f
rtl/core/mde_pkg.sv
rtl/core/mde_ram.sv
rtl/core/maze_depth_first_explorer_top.sv
test/tb.sv
